/* rtl/cct_pkg.sv */
package cct_pkg;

    typedef enum logic [1:0] {
        K_EXPECT  = 2'd0,
        K_WROTE   = 2'd1,
        K_NO_MORE = 2'd2,
        K_TAKE    = 2'd3
    } t_kind;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;

    localparam logic REG_ROWS   = 1'b0;
    localparam logic REG_CCOUNT = 1'b1;

    localparam int ROWS_W = 17;
    localparam int CCNT_W = 11;
    localparam int REF_W  = 31;
    localparam int IDX_W  = 10;
    localparam int DCNT_W = 5;

    // command handed from the front end to the back end
    typedef struct packed {
        t_kind kind;
        logic  oor;
    } t_cmd;

endpackage

/* rtl/cct_ram.sv */
module cct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/cct_front.sv */
module cct_front import cct_pkg::*; #(
    parameter int MAX_CHUNKS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [ROWS_W-1:0]             i_rows,
    input  logic [$clog2(MAX_CHUNKS):0]   i_lim,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [1:0]                    i_kind,
    input  logic [REF_W-1:0]              i_reference_index,
    output logic                          o_cmd_vld,
    output t_cmd                          o_cmd,
    output logic [$clog2(MAX_CHUNKS)-1:0] o_chunk,
    input  logic                          i_cmd_pop
);

    localparam int CI_W = $clog2(MAX_CHUNKS);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_PUT} t_state;

    t_state              r_state;
    logic [ROWS_W-1:0]   r_div;
    logic [ROWS_W-1:0]   r_rem;
    logic [REF_W-1:0]    r_quo;
    logic [DCNT_W-1:0]   r_cnt;
    t_kind               r_kind;

    t_kind               r_qkind  [2];
    logic                r_qoor   [2];
    logic [CI_W-1:0]     r_qchunk [2];
    logic                r_wp;
    logic                r_rp;
    logic [1:0]          r_qcnt;

    logic                accept;
    logic [ROWS_W:0]     trial;
    logic                ge;
    logic                q_wr;
    t_kind               w_kind;
    logic                w_oor;
    logic [CI_W-1:0]     w_chunk;

    assign o_full = (r_state != S_IDLE) || (r_qcnt == 2'd2);
    assign accept = i_push && !o_full;
    assign trial  = {r_rem, r_quo[REF_W-1]};
    assign ge     = trial >= {1'b0, r_div};

    always_comb begin
        q_wr    = 1'b0;
        w_kind  = t_kind'(i_kind);
        w_oor   = 1'b0;
        w_chunk = '0;
        if (r_state == S_IDLE) begin
            q_wr = accept && (t_kind'(i_kind) == K_NO_MORE || t_kind'(i_kind) == K_TAKE);
        end else if (r_state == S_PUT) begin
            q_wr    = (r_qcnt != 2'd2);
            w_kind  = r_kind;
            w_oor   = 32'(r_quo) >= 32'(i_lim);
            w_chunk = r_quo[CI_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_qcnt  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept && (t_kind'(i_kind) == K_EXPECT || t_kind'(i_kind) == K_WROTE)) begin
                        r_kind  <= t_kind'(i_kind);
                        r_div   <= (i_rows == '0) ? ROWS_W'(1) : i_rows;
                        r_rem   <= '0;
                        r_quo   <= i_reference_index;
                        r_cnt   <= DCNT_W'(REF_W - 1);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // restoring divide, one quotient bit per cycle
                    r_rem <= ge ? ROWS_W'(trial - {1'b0, r_div}) : trial[ROWS_W-1:0];
                    r_quo <= {r_quo[REF_W-2:0], ge};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (q_wr) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (q_wr) begin
                r_qkind[r_wp]  <= w_kind;
                r_qoor[r_wp]   <= w_oor;
                r_qchunk[r_wp] <= w_chunk;
                r_wp           <= !r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= !r_rp;
            end
            r_qcnt <= r_qcnt + {1'b0, q_wr} - {1'b0, i_cmd_pop};
        end
    end

    assign o_cmd_vld = (r_qcnt != 2'd0);
    assign o_cmd     = '{kind: r_qkind[r_rp], oor: r_qoor[r_rp]};
    assign o_chunk   = r_qchunk[r_rp];

endmodule

/* rtl/cct_back.sv */
module cct_back import cct_pkg::*; #(
    parameter int MAX_CHUNKS = 1024,
    parameter int COUNT_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [$clog2(MAX_CHUNKS):0]   i_lim,
    input  logic                          i_cmd_vld,
    input  t_cmd                          i_cmd,
    input  logic [$clog2(MAX_CHUNKS)-1:0] i_chunk,
    output logic                          o_cmd_pop,
    input  logic                          i_pop,
    output logic                          o_empty,
    output logic [1:0]                    o_status,
    output logic                          o_found,
    output logic [IDX_W-1:0]              o_chunk_index
);

    localparam int CI_W  = $clog2(MAX_CHUNKS);
    localparam int LIM_W = CI_W + 1;
    localparam int MW    = COUNT_BITS + 2;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_EXEC, S_TAKE, S_SCAN_RD, S_SCAN_CHK
    } t_state;

    t_state             r_state, n_state;
    logic [CI_W-1:0]    r_cur, n_cur;
    logic [CI_W-1:0]    r_end, n_end;
    t_kind              r_kind, n_kind;
    logic [CI_W-1:0]    r_hw, n_hw;
    logic               r_hw_vld, n_hw_vld;
    logic               r_done, n_done;
    logic [LIM_W-1:0]   r_head, n_head;
    logic [LIM_W-1:0]   r_tail, n_tail;
    logic               r_ovld, n_ovld;
    logic [1:0]         r_status, n_status;
    logic               r_found, n_found;
    logic [IDX_W-1:0]   r_idx, n_idx;

    logic               m_we;
    logic [CI_W-1:0]    m_raddr;
    logic [MW-1:0]      m_wdata;
    logic [MW-1:0]      m_rdata;
    logic               q_we;
    logic [CI_W-1:0]    q_rdata;

    logic [COUNT_BITS-1:0] e_cnt;
    logic                  e_tch;
    logic                  e_set;
    logic [COUNT_BITS-1:0] dec;
    logic                  settle;
    logic                  o_free;
    logic                  load;
    logic [CI_W-1:0]       start;

    // entry layout: {settled, touched, outstanding count}
    assign e_cnt = m_rdata[COUNT_BITS-1:0];
    assign e_tch = m_rdata[COUNT_BITS];
    assign e_set = m_rdata[COUNT_BITS+1];
    assign dec   = e_cnt - 1'b1;
    assign start = r_hw_vld ? r_hw : '0;

    cct_ram #(.WIDTH(MW), .DEPTH(MAX_CHUNKS)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (r_cur),
        .i_wdata (m_wdata),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    cct_ram #(.WIDTH(CI_W), .DEPTH(MAX_CHUNKS)) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (r_tail[CI_W-1:0]),
        .i_wdata (r_cur),
        .i_raddr (r_head[CI_W-1:0]),
        .o_rdata (q_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_cur     = r_cur;
        n_end     = r_end;
        n_kind    = r_kind;
        n_hw      = r_hw;
        n_hw_vld  = r_hw_vld;
        n_done    = r_done;
        n_head    = r_head;
        n_tail    = r_tail;
        o_free    = !r_ovld || i_pop;
        n_ovld    = r_ovld && !i_pop;
        n_status  = r_status;
        n_found   = r_found;
        n_idx     = r_idx;
        load      = 1'b0;
        m_we      = 1'b0;
        m_wdata   = '0;
        m_raddr   = r_cur;
        q_we      = 1'b0;
        o_cmd_pop = 1'b0;
        settle    = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                m_we  = 1'b1;
                n_cur = r_cur + 1'b1;
                if (r_cur == CI_W'(MAX_CHUNKS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                m_raddr = i_chunk;
                if (i_cmd_vld && o_free) begin
                    o_cmd_pop = 1'b1;
                    n_cur     = i_chunk;
                    n_kind    = i_cmd.kind;
                    if (i_cmd.oor && (i_cmd.kind == K_EXPECT || i_cmd.kind == K_WROTE)) begin
                        load     = 1'b1;
                        n_status = ST_RANGE;
                    end else begin
                        unique case (i_cmd.kind)
                            K_EXPECT, K_WROTE: n_state = S_EXEC;
                            K_TAKE: begin
                                if (r_head < r_tail) begin
                                    n_state = S_TAKE;
                                end else begin
                                    load = 1'b1;
                                end
                            end
                            K_NO_MORE: begin
                                n_done = 1'b1;
                                if (i_lim == '0) begin
                                    load = 1'b1;
                                end else begin
                                    n_cur   = '0;
                                    n_end   = CI_W'(i_lim - 1'b1);
                                    n_state = S_SCAN_RD;
                                end
                            end
                            default: load = 1'b1;
                        endcase
                    end
                end
            end
            S_EXEC: begin
                if (o_free) begin
                    n_state = S_IDLE;
                    if (r_kind == K_EXPECT) begin
                        m_we    = 1'b1;
                        m_wdata = {e_set, 1'b1, (e_cnt == COUNT_MAX) ? e_cnt : e_cnt + 1'b1};
                        if (!r_hw_vld || r_cur > r_hw) begin
                            // mark advances: chunks from the old mark up to c-1 get offered
                            n_hw     = r_cur;
                            n_hw_vld = 1'b1;
                            if (start < r_cur) begin
                                n_cur   = start;
                                n_end   = r_cur - 1'b1;
                                n_state = S_SCAN_RD;
                            end else begin
                                load = 1'b1;
                            end
                        end else begin
                            load = 1'b1;
                        end
                    end else begin
                        load = 1'b1;
                        if (e_cnt == '0) begin
                            n_status = ST_ZERO;
                        end else begin
                            settle  = (dec == '0) && !e_set && e_tch &&
                                      (r_done || (r_hw_vld && r_hw > r_cur));
                            m_we    = 1'b1;
                            m_wdata = {e_set | settle, e_tch, dec};
                        end
                    end
                end
            end
            S_TAKE: begin
                if (o_free) begin
                    load    = 1'b1;
                    n_found = 1'b1;
                    n_idx   = IDX_W'(q_rdata);
                    n_head  = r_head + 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SCAN_RD: n_state = S_SCAN_CHK;
            S_SCAN_CHK: begin
                if (o_free) begin
                    settle  = !e_set && e_tch && (e_cnt == '0);
                    m_we    = settle;
                    m_wdata = {1'b1, e_tch, e_cnt};
                    if (r_cur == r_end) begin
                        load    = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_cur   = r_cur + 1'b1;
                        n_state = S_SCAN_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (settle) begin
            q_we   = 1'b1;
            n_tail = r_tail + 1'b1;
        end
        if (load) begin
            n_ovld = 1'b1;
            if (!(r_state == S_EXEC && r_kind == K_WROTE && e_cnt == '0) &&
                !(r_state == S_IDLE && i_cmd.oor)) begin
                n_status = ST_OK;
            end
            if (r_state != S_TAKE) begin
                n_found = 1'b0;
                n_idx   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_cur    <= '0;
            r_hw_vld <= 1'b0;
            r_done   <= 1'b0;
            r_head   <= '0;
            r_tail   <= '0;
            r_ovld   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cur    <= n_cur;
            r_hw_vld <= n_hw_vld;
            r_done   <= n_done;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_ovld   <= n_ovld;
        end
        r_end    <= n_end;
        r_kind   <= n_kind;
        r_hw     <= n_hw;
        r_status <= n_status;
        r_found  <= n_found;
        r_idx    <= n_idx;
    end

    assign o_empty       = !r_ovld;
    assign o_status      = r_status;
    assign o_found       = r_found;
    assign o_chunk_index = r_idx;

    a_head_le_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail) else $error("settled queue head passed tail");
    a_no_cmd_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_cmd_pop) else $error("command taken during clear");
    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (!r_ovld || i_pop)) else $error("result overwritten");
    a_tail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_tail) <= 32'(MAX_CHUNKS)) else $error("settled queue overflow");

endmodule

/* rtl/chunk_completion_tracker.sv */
// channel   direction  handshake       payload
// input     in         i_push / o_full i_kind, i_reference_index
// result    out        o_empty / i_pop o_status, o_found, o_chunk_index
// config    in         i_cfg_we        i_cfg_idx, i_cfg_data
//
// Expect and wrote items pass a bit-serial divide of the reference by the row count per
// chunk in the front end, then go on to the back end. A scan reads and then checks each
// chunk in turn (S_SCAN_RD, S_SCAN_CHK), as there is one RAM read port.
// After reset a clearing pass zeroes every entry of the count table; items queue but are not executed.
// A two-entry command queue sits between the front and back; the back end holds while
// an unpopped result waits, and the front end keeps filling the queue.
module chunk_completion_tracker import cct_pkg::*; #(
    parameter int MAX_CHUNKS = 1024,
    parameter int COUNT_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [ROWS_W-1:0]  i_cfg_data,
    input  logic               i_push,
    output logic               o_full,
    input  logic [1:0]         i_kind,
    input  logic [REF_W-1:0]   i_reference_index,
    output logic               o_empty,
    input  logic               i_pop,
    output logic [1:0]         o_status,
    output logic               o_found,
    output logic [IDX_W-1:0]   o_chunk_index
);

    localparam int CI_W  = $clog2(MAX_CHUNKS);
    localparam int LIM_W = CI_W + 1;

    logic [ROWS_W-1:0] r_rows;
    logic [CCNT_W-1:0] r_ccount;
    logic [LIM_W-1:0]  lim;
    logic              cmd_vld;
    logic              cmd_pop;
    t_cmd              cmd;
    logic [CI_W-1:0]   cmd_chunk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows   <= ROWS_W'(1);
            r_ccount <= CCNT_W'(1024);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ROWS:   r_rows   <= i_cfg_data;
                REG_CCOUNT: r_ccount <= i_cfg_data[CCNT_W-1:0];
                default:    r_rows   <= r_rows;
            endcase
        end
    end

    assign lim = (32'(r_ccount) > 32'(MAX_CHUNKS)) ? LIM_W'(MAX_CHUNKS) : LIM_W'(r_ccount);

    cct_front #(.MAX_CHUNKS(MAX_CHUNKS)) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_rows            (r_rows),
        .i_lim             (lim),
        .i_push            (i_push),
        .o_full            (o_full),
        .i_kind            (i_kind),
        .i_reference_index (i_reference_index),
        .o_cmd_vld         (cmd_vld),
        .o_cmd             (cmd),
        .o_chunk           (cmd_chunk),
        .i_cmd_pop         (cmd_pop)
    );

    cct_back #(.MAX_CHUNKS(MAX_CHUNKS), .COUNT_BITS(COUNT_BITS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_lim         (lim),
        .i_cmd_vld     (cmd_vld),
        .i_cmd         (cmd),
        .i_chunk       (cmd_chunk),
        .o_cmd_pop     (cmd_pop),
        .i_pop         (i_pop),
        .o_empty       (o_empty),
        .o_status      (o_status),
        .o_found       (o_found),
        .o_chunk_index (o_chunk_index)
    );

endmodule

/* dv/tb.sv */
module tb;
    import cct_pkg::*;

    localparam int NCHUNK = 1024;
    // idle margin of a full scan before the next register write
    localparam int SETTLE_CYCLES = 2 * NCHUNK + 200;

    typedef struct {
        logic [1:0]       status;
        logic             found;
        logic [IDX_W-1:0] chunk;
    } chunk_result_t;

    typedef struct {
        t_kind         kind;
        logic [30:0]   ref_idx;
        bit            typed;
        chunk_result_t want;
    } stim_row_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic              i_cfg_idx = 1'b0;
    logic [ROWS_W-1:0] i_cfg_data = '0;
    logic              i_push = 1'b0;
    logic              o_full;
    logic [1:0]        i_kind = K_EXPECT;
    logic [REF_W-1:0]  i_reference_index = '0;
    logic              o_empty;
    logic              i_pop = 1'b0;
    logic [1:0]        o_status;
    logic              o_found;
    logic [IDX_W-1:0]  o_chunk_index;

    chunk_completion_tracker dut (.*);

    always #5 i_clk = ~i_clk;

    // tracker image
    logic [ROWS_W-1:0] rows_reg;
    logic [CCNT_W-1:0] ccount_reg;
    logic [31:0]       pend_cnt [NCHUNK];
    bit                touched [NCHUNK];
    bit                settled [NCHUNK];
    int                high_water;
    bit                loader_done;
    int                settled_fifo [$];

    chunk_result_t     pending_results [$];
    stim_row_t         dir_rows [$];
    int                errors = 0;
    int                burst_left = 0;
    bit                hold_req = 1'b0;
    bit                hold_done = 1'b0;
    int                hold_cnt = 0;
    int                stall_mode = 0;
    int                mode_cnt = 0;

    task automatic report(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic int live_chunks();
        return (ccount_reg > NCHUNK) ? NCHUNK : int'(ccount_reg);
    endfunction

    function automatic int eff_rows();
        return (rows_reg == 0) ? 1 : int'(rows_reg);
    endfunction

    function automatic void try_settle(input int c);
        if (c >= NCHUNK || settled[c] || !touched[c] || pend_cnt[c] != 0) return;
        if (!(loader_done || high_water > c)) return;
        settled[c] = 1'b1;
        settled_fifo.push_back(c);
    endfunction

    function automatic void settle_span(input int from, input int through);
        int lim;
        lim = live_chunks();
        if (from < 0) from = 0;
        for (int c = from; c <= through && c < lim; c++) try_settle(c);
    endfunction

    function automatic chunk_result_t track_item(input t_kind k, input logic [30:0] r);
        chunk_result_t res;
        longint c;
        int prev;
        res = '{ST_OK, 1'b0, '0};
        if (k == K_EXPECT || k == K_WROTE) begin
            c = longint'(r) / eff_rows();
            if (c >= live_chunks()) begin
                res.status = ST_RANGE;
            end else if (k == K_EXPECT) begin
                if (pend_cnt[c] != 32'hFFFF_FFFF) pend_cnt[c]++;
                touched[c] = 1'b1;
                if (c > high_water) begin
                    prev = high_water;
                    high_water = int'(c);
                    settle_span(prev, int'(c) - 1);
                end
            end else if (pend_cnt[c] == 0) begin
                res.status = ST_ZERO;
            end else begin
                pend_cnt[c]--;
                if (pend_cnt[c] == 0) try_settle(int'(c));
            end
        end else if (k == K_NO_MORE) begin
            loader_done = 1'b1;
            settle_span(0, live_chunks() - 1);
        end else if (settled_fifo.size() > 0) begin
            res.found = 1'b1;
            res.chunk = IDX_W'(settled_fifo.pop_front());
        end
        return res;
    endfunction

    task automatic send(input t_kind k, input logic [30:0] r, input bit typed,
                        input chunk_result_t want);
        chunk_result_t got;
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        i_push <= 1'b1;
        i_kind <= k;
        i_reference_index <= r;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        got = track_item(k, r);
        pending_results.push_back(typed ? want : got);
    endtask

    task automatic drain();
        i_push <= 1'b0;
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [ROWS_W-1:0] rows, input logic [CCNT_W-1:0] cc);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= REG_ROWS;
        i_cfg_data <= rows;
        @(posedge i_clk);
        i_cfg_idx <= REG_CCOUNT;
        i_cfg_data <= ROWS_W'(cc);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        rows_reg = rows;
        ccount_reg = cc;
    endtask

    task automatic add_row(input t_kind k, input logic [30:0] r, input bit typed,
                           input logic [1:0] st, input logic f, input int idx);
        stim_row_t row;
        row.kind = k;
        row.ref_idx = r;
        row.typed = typed;
        row.want = '{st, f, IDX_W'(idx)};
        dir_rows.push_back(row);
    endtask

    task automatic random_items(input int n, input bit allow_done);
        int sel, lim, rows, base, c;
        longint r;
        t_kind k;
        chunk_result_t none;
        none = '{ST_OK, 1'b0, '0};
        for (int i = 0; i < n; i++) begin
            lim = live_chunks();
            rows = eff_rows();
            sel = $urandom_range(0, 99);
            if (sel < 45) k = K_EXPECT;
            else if (sel < 80) k = K_WROTE;
            else if (sel < 98 || !allow_done) k = K_TAKE;
            else k = K_NO_MORE;
            base = (high_water < 0) ? 0 : high_water;
            c = (base > 2 ? base - 2 : 0) + $urandom_range(0, 4);
            if (k == K_EXPECT && $urandom_range(0, 19) == 0)
                c = base + $urandom_range(3, 20);
            if (k == K_WROTE && $urandom_range(0, 4) != 0) begin
                for (int j = base; j >= 0 && j > base - 6; j--)
                    if (pend_cnt[j] != 0) begin
                        c = j;
                        break;
                    end
            end
            if (lim > 0 && c >= lim) c = $urandom_range(0, lim - 1);
            r = longint'(c) * rows + $urandom_range(0, rows - 1);
            if ($urandom_range(0, 11) == 0 || k == K_TAKE || k == K_NO_MORE)
                r = $urandom;
            send(k, r[30:0], 1'b0, none);
        end
    endtask

    // result side: pattern stalls plus one long hold-off to back the block up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else if (hold_req && !hold_done) begin
            i_pop <= 1'b0;
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt == 400) hold_done <= 1'b1;
        end else begin
            if (mode_cnt == 0) begin
                stall_mode <= $urandom_range(0, 2);
                mode_cnt <= $urandom_range(16, 96);
            end else begin
                mode_cnt <= mode_cnt - 1;
            end
            case (stall_mode)
                0: i_pop <= 1'b1;
                1: i_pop <= ($urandom_range(0, 3) != 0);
                default: i_pop <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        chunk_result_t exp_r;
        if (i_rst_n && i_pop && !o_empty) begin
            if (pending_results.size() == 0) begin
                report("result with no transaction outstanding");
            end else begin
                exp_r = pending_results.pop_front();
                if (o_status !== exp_r.status)
                    report($sformatf("status %0d want %0d", o_status, exp_r.status));
                if (o_found !== exp_r.found)
                    report($sformatf("found %0d want %0d", o_found, exp_r.found));
                if (o_chunk_index !== exp_r.chunk)
                    report($sformatf("chunk %0d want %0d", o_chunk_index, exp_r.chunk));
            end
        end
    end

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        chunk_result_t none;
        none = '{ST_OK, 1'b0, '0};
        for (int c = 0; c < NCHUNK; c++) begin
            pend_cnt[c] = 0;
            touched[c] = 1'b0;
            settled[c] = 1'b0;
        end
        high_water = -1;
        loader_done = 1'b0;
        rows_reg = 1;
        ccount_reg = 1024;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_regs(17'd1, 11'd1024);

        add_row(K_EXPECT, 31'd0, 1, ST_OK, 0, 0);
        add_row(K_WROTE, 31'd0, 1, ST_OK, 0, 0);
        add_row(K_WROTE, 31'd0, 1, ST_ZERO, 0, 0);
        add_row(K_EXPECT, 31'h7FFF_FFFF, 1, ST_RANGE, 0, 0);
        add_row(K_WROTE, 31'h7FFF_FFFF, 1, ST_RANGE, 0, 0);
        add_row(K_TAKE, 31'h5555_5555, 1, ST_OK, 0, 0);
        add_row(K_EXPECT, 31'd1, 0, ST_OK, 0, 0);
        add_row(K_TAKE, 31'h2AAA_AAAA, 1, ST_OK, 1, 0);
        add_row(K_TAKE, 31'd0, 1, ST_OK, 0, 0);
        add_row(K_EXPECT, 31'd1023, 0, ST_OK, 0, 0);
        add_row(K_EXPECT, 31'd1024, 1, ST_RANGE, 0, 0);
        add_row(K_WROTE, 31'd1, 0, ST_OK, 0, 0);
        add_row(K_TAKE, 31'd0, 0, ST_OK, 0, 0);
        add_row(K_EXPECT, 31'd500, 0, ST_OK, 0, 0);
        add_row(K_EXPECT, 31'd500, 0, ST_OK, 0, 0);
        add_row(K_WROTE, 31'd500, 0, ST_OK, 0, 0);
        add_row(K_WROTE, 31'd500, 0, ST_OK, 0, 0);
        add_row(K_WROTE, 31'd1023, 0, ST_OK, 0, 0);
        add_row(K_TAKE, 31'd0, 0, ST_OK, 0, 0);
        add_row(K_TAKE, 31'd0, 0, ST_OK, 0, 0);
        foreach (dir_rows[i])
            send(dir_rows[i].kind, dir_rows[i].ref_idx, dir_rows[i].typed, dir_rows[i].want);
        drain();

        write_regs(17'd3, 11'd16);
        hold_req = 1'b1;
        random_items(300, 0);
        drain();
        write_regs(17'd65536, 11'd1024);
        random_items(200, 0);
        drain();
        // zero rows behaves as one row per chunk
        write_regs(17'd0, 11'd1);
        random_items(150, 0);
        drain();
        // no chunk in use: every reference is out of range, the scan is empty
        write_regs(17'd7, 11'd0);
        send(K_NO_MORE, 31'd0, 1, none);
        random_items(50, 1);
        drain();
        // oversized count clamps to the full table
        write_regs(17'd2, 11'd2047);
        random_items(500, 1);
        drain();
        write_regs(17'd5, 11'd40);
        random_items(350, 1);
        send(K_NO_MORE, 31'h7FFF_FFFF, 0, none);
        repeat (60) send(K_TAKE, 31'd0, 0, none);
        drain();

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
